@@ src/izsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image zoom source address generator package
// Shared types and constants for the screen-to-flash address pipeline.
// ----------------------------------------------------------------------------
package izsa_pkg;

    // Screen and flash layout.
    localparam int SCREEN_W     = 240;
    localparam int SCREEN_H     = 320;
    localparam int SLOT_BYTES   = 131072;
    localparam int MAX_SLOTS    = 64;
    localparam int SLOT_SHIFT   = $clog2(SLOT_BYTES);
    localparam int FLASH_BASE   = 65536;
    localparam int HEADER_BYTES = 32;
    localparam int COORD_MAX    = 511;

    localparam logic [31:0] TAG_WORD = 32'h494D_4731;

    // Fit-mode division by the screen size is split into a shift and a
    // small odd divisor, which is then done by a reciprocal multiply.
    // 240 = 16 * 15 and 320 = 64 * 5. The reciprocals are exact for all
    // products of an on-screen coordinate and a 10-bit image size.
    localparam int           FIT_X_SHIFT = 4;
    localparam logic [16:0]  RECIP_X     = 17'd69906;   // ceil(2^20 / 15)
    localparam int           RECIP_X_SH  = 20;
    localparam int           FIT_Y_SHIFT = 6;
    localparam logic [13:0]  RECIP_Y     = 14'd13108;   // ceil(2^16 / 5)
    localparam int           RECIP_Y_SH  = 16;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SCALE_MODE   = 3'd0,
        REG_IMAGE_SLOT   = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_HEADER_MAGIC = 3'd4
    } t_reg_idx;

    // Zoom modes.
    typedef enum logic [1:0] {
        ZOOM_ORIGINAL  = 2'd0,
        ZOOM_DOUBLE    = 2'd1,
        ZOOM_TO_SCREEN = 2'd2
    } t_zoom;

    typedef struct packed {
        logic [1:0]  scale_mode;
        logic [5:0]  image_slot;
        logic [9:0]  image_width;
        logic [9:0]  image_height;
        logic [31:0] header_magic;
    } t_cfg;

    typedef struct packed {
        logic [7:0] screen_x;
        logic [8:0] screen_y;
    } t_in_item;

    typedef struct packed {
        logic        show_source;
        logic [8:0]  source_col;
        logic [8:0]  source_row;
        logic [23:0] source_address;
    } t_out_item;

    // Result of the coordinate mapping stages.
    typedef struct packed {
        logic       ok;
        logic [8:0] col;
        logic [8:0] row;
    } t_map;

endpackage

@@ src/izsa_coord_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate mapping stages
// Maps a screen position to a source column and row in two register stages.
// ----------------------------------------------------------------------------
module izsa_coord_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  izsa_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  izsa_pkg::t_in_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output izsa_pkg::t_map     o_map
);
    import izsa_pkg::*;

    localparam logic [10:0] SW = 11'(SCREEN_W);
    localparam logic [10:0] SH = 11'(SCREEN_H);

    // Stage 1 registers.
    logic        r_v1;
    logic        r_ok1;
    logic        r_fit1;
    logic [9:0]  r_col1;
    logic [9:0]  r_row1;
    logic [17:0] r_px1;
    logic [18:0] r_py1;

    // Stage 2 registers.
    logic        r_v2;
    t_map        r_map2;

    logic        s1_ready;
    logic        s2_ready;

    logic        base_ok;
    logic [10:0] ox;
    logic [10:0] oy;
    logic [10:0] c0;
    logic [10:0] r0;
    logic        in0;
    logic        in1;
    logic        n_ok1;
    logic        n_fit1;
    logic [9:0]  n_col1;
    logic [9:0]  n_row1;

    logic [30:0] qx_prod;
    logic [26:0] qy_prod;
    logic [10:0] qx;
    logic [10:0] qy;
    logic [10:0] col2;
    logic [10:0] row2;
    t_map        n_map2;

    assign s2_ready = !r_v2 || i_ready;
    assign s1_ready = !r_v1 || s2_ready;
    assign o_ready  = s1_ready;

    // Stage 1: range checks, original-size and double-size mapping, and the
    // products for fit mode.
    always_comb begin
        base_ok = (i_cfg.header_magic == TAG_WORD)
               && (i_cfg.image_width != '0) && (i_cfg.image_height != '0)
               && (32'(i_cfg.image_slot) < MAX_SLOTS)
               && (32'(i_item.screen_x) < SCREEN_W)
               && (32'(i_item.screen_y) < SCREEN_H);

        ox = ({1'b0, i_cfg.image_width} >= SW) ? '0
           : ((SW - {1'b0, i_cfg.image_width}) >> 1);
        oy = ({1'b0, i_cfg.image_height} >= SH) ? '0
           : ((SH - {1'b0, i_cfg.image_height}) >> 1);
        c0 = {3'b0, i_item.screen_x} - ox;
        r0 = {2'b0, i_item.screen_y} - oy;
        in0 = ({3'b0, i_item.screen_x} >= ox) && ({2'b0, i_item.screen_y} >= oy)
           && (c0 < {1'b0, i_cfg.image_width}) && (r0 < {1'b0, i_cfg.image_height});
        in1 = ({3'b0, i_item.screen_x[7:1]} < i_cfg.image_width)
           && ({2'b0, i_item.screen_y[8:1]} < i_cfg.image_height);

        n_fit1 = 1'b0;
        n_col1 = '0;
        n_row1 = '0;
        unique case (i_cfg.scale_mode)
            ZOOM_ORIGINAL: begin
                n_ok1  = base_ok && in0;
                n_col1 = c0[9:0];
                n_row1 = r0[9:0];
            end
            ZOOM_DOUBLE: begin
                n_ok1  = base_ok && in1;
                n_col1 = {3'b0, i_item.screen_x[7:1]};
                n_row1 = {2'b0, i_item.screen_y[8:1]};
            end
            ZOOM_TO_SCREEN: begin
                n_ok1  = base_ok;
                n_fit1 = 1'b1;
            end
            default: begin
                n_ok1 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_ok1  <= n_ok1;
            r_fit1 <= n_fit1;
            r_col1 <= n_col1;
            r_row1 <= n_row1;
            r_px1  <= 18'(i_item.screen_x) * 18'(i_cfg.image_width);
            r_py1  <= 19'(i_item.screen_y) * 19'(i_cfg.image_height);
        end
    end

    // Stage 2: fit-mode division by reciprocal multiply, then the final
    // coordinate range check.
    always_comb begin
        qx_prod = 31'(r_px1[17:FIT_X_SHIFT]) * 31'(RECIP_X);
        qy_prod = 27'(r_py1[18:FIT_Y_SHIFT]) * 27'(RECIP_Y);
        qx      = qx_prod[30:RECIP_X_SH];
        qy      = qy_prod[26:RECIP_Y_SH];
        col2    = r_fit1 ? qx : {1'b0, r_col1};
        row2    = r_fit1 ? qy : {1'b0, r_row1};
        n_map2.ok  = r_ok1 && (32'(col2) <= COORD_MAX) && (32'(row2) <= COORD_MAX);
        n_map2.col = col2[8:0];
        n_map2.row = row2[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_ready) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready) begin
            r_map2 <= n_map2;
        end
    end

    assign o_valid = r_v2;
    assign o_map   = r_map2;

endmodule

@@ src/image_zoom_source_address_generator.sv @@
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output is taken; four register
// stages (checks and products, reciprocal division, row-times-width multiply, address add).
// Reset empties the pipeline and sets the registers to fit mode, slot 0,
// a zero-size image and a zero header magic.
// ----------------------------------------------------------------------------
// Image zoom source address generator
// For each screen pixel gives the flash byte address of the RGB565 source
// pixel to show there, or a black-fill result.
// ----------------------------------------------------------------------------
module image_zoom_source_address_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_wdata,
    // Screen position items.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  izsa_pkg::t_in_item  i_in_data,
    // Source address items.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output izsa_pkg::t_out_item o_out_data
);
    import izsa_pkg::*;

    // Configuration registers. The user must change them only while the pipeline
    // is idle; the block itself does not enforce this. Every stage reads them directly.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_mode   <= ZOOM_TO_SCREEN;
            r_cfg.image_slot   <= '0;
            r_cfg.image_width  <= '0;
            r_cfg.image_height <= '0;
            r_cfg.header_magic <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCALE_MODE:   r_cfg.scale_mode   <= i_cfg_wdata[1:0];
                REG_IMAGE_SLOT:   r_cfg.image_slot   <= i_cfg_wdata[5:0];
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_wdata[9:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_wdata[9:0];
                REG_HEADER_MAGIC: r_cfg.header_magic <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Stages 1 and 2: screen position to source column and row.
    logic map_valid;
    logic map_ready;
    t_map map_out;

    izsa_coord_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .o_valid (map_valid),
        .i_ready (map_ready),
        .o_map   (map_out)
    );

    // Each stage moves on when it is empty or when the next stage moves, so
    // a full pipeline keeps accepting one item per cycle while the output
    // is taken, and in a full pipeline a stall holds every stage in place.
    logic        r_v3;
    t_map        r_map3;
    logic [18:0] r_prod3;
    logic        r_v4;
    t_out_item   r_out4;

    logic        s3_ready;
    logic        s4_ready;
    logic [19:0] pix_index;
    logic [23:0] slot_base;
    t_out_item   n_out4;

    assign s4_ready  = !r_v4 || i_out_ready;
    assign s3_ready  = !r_v3 || s4_ready;
    assign map_ready = s3_ready;

    // Stage 3: row times the image width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (s3_ready) begin
            r_v3 <= map_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready) begin
            r_map3  <= map_out;
            r_prod3 <= 19'(map_out.row) * 19'(r_cfg.image_width);
        end
    end

    // Stage 4: byte address. The slot size is a power of two, so the slot
    // base is a shift. Everything wraps to 24 bits. A black result carries
    // zero in every field.
    always_comb begin
        pix_index = 20'(r_prod3) + 20'(r_map3.col);
        slot_base = 24'({r_cfg.image_slot, SLOT_SHIFT'(0)});
        n_out4    = '0;
        if (r_map3.ok) begin
            n_out4.show_source    = 1'b1;
            n_out4.source_col     = r_map3.col;
            n_out4.source_row     = r_map3.row;
            n_out4.source_address = 24'(FLASH_BASE + HEADER_BYTES) + slot_base
                                  + 24'({pix_index, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (s4_ready) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_ready) begin
            r_out4 <= n_out4;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_data  = r_out4;

`ifndef ASSERT_OFF
    // A black item carries zero in every other field.
    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.show_source |->
            o_out_data.source_col == '0 && o_out_data.source_row == '0
            && o_out_data.source_address == '0)
        else $error("black item with nonzero fields");

    // Pixel addresses are always even.
    a_addr_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.show_source |-> !o_out_data.source_address[0])
        else $error("odd source address");

    // When the output is being taken, the whole pipeline can move.
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output is taken");

    // An item taken at the output leaves the final stage unless one moves in.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !r_v3 |=> !o_out_valid)
        else $error("output item repeated");
`endif

endmodule
